// ===== rtl/pot_to_attenuation_ramp_top_macros.svh =====
// Assertion macros used by the back end (pta_back) of the attenuation ramp RTL.
`ifndef POT_TO_ATTENUATION_RAMP_TOP_MACROS_SVH
`define POT_TO_ATTENUATION_RAMP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pta_pkg.sv =====
// Types, constants and the target mapping of the attenuation ramp.
package pta_pkg;

   localparam logic [7:0] NO_POT_THRESHOLD = 8'hE0;
   localparam logic [7:0] FULL_SCALE       = 8'hFF;
   localparam logic [6:0] QUOTIENT_CAP     = 7'd80;
   localparam logic [6:0] MAX_ATTEN        = 7'd64;
   localparam logic [7:0] RECIP_THREE      = 8'd171;
   localparam logic [3:0] DIV_LAST_STEP    = 4'd15;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic {
      B_IDLE,
      B_RAMP
   } back_state_type;

   typedef struct packed {
      logic       valid;
      logic [6:0] target;
   } tgt_beat_type;

   function automatic logic [6:0] target_of(input logic [15:0] quot, input logic reverse);
      logic [7:0]  lin;
      logic [15:0] prod;
      logic [6:0]  q;
      logic [6:0]  t;
      lin = (quot[15:8] != 8'd0) ? FULL_SCALE : quot[7:0];
      if (!reverse) begin
         lin = FULL_SCALE - lin;
      end
      prod = {8'd0, lin} * {8'd0, RECIP_THREE};
      q = prod[15:9];
      if (q > QUOTIENT_CAP) begin
         q = QUOTIENT_CAP;
      end
      t = QUOTIENT_CAP - q;
      if (t > MAX_ATTEN) begin
         t = MAX_ATTEN;
      end
      return t;
   endfunction

endpackage

// ===== rtl/pta_ifs.sv =====
// Channel interfaces of the attenuation ramp: sample, step and register write.
interface pta_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pot_sample;
   modport source (output valid, output pot_sample, input ready);
   modport sink (input valid, input pot_sample, output ready);
endinterface

interface pta_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] attenuation_db;
   logic       last_step;
   modport source (output valid, output attenuation_db, output last_step, input ready);
   modport sink (input valid, input attenuation_db, input last_step, output ready);
endinterface

interface pta_csr_if;
   logic valid;
   logic ready;
   logic reverse_direction;
   modport source (output valid, output reverse_direction, input ready);
   modport sink (input valid, input reverse_direction, output ready);
endinterface

// ===== rtl/pta_front.sv =====
// Front end: accepts pot samples, runs the linearizing division and forms the target.
module pta_front (
   input  logic                  clock,
   input  logic                  reset,
   pta_req_if.sink               req,
   pta_csr_if.sink               csr,
   output pta_pkg::tgt_beat_type push,
   input  logic                  push_ready
);

   pta_pkg::front_state_type state_ff, state_in;
   logic [15:0] dvd_ff, dvd_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  den_ff, den_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        nopot_ff, nopot_in;
   logic        reverse_ff, reverse_in;
   logic        accept;
   logic [8:0]  rem_sh;
   logic [9:0]  diff;
   logic        fits;

   assign accept = req.valid && req.ready;
   assign rem_sh = {rem_ff, dvd_ff[15]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};
   assign fits   = !diff[9];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pta_pkg::F_IDLE: begin
            if (accept) begin
               state_in = (req.pot_sample > pta_pkg::NO_POT_THRESHOLD) ?
                          pta_pkg::F_PUSH : pta_pkg::F_DIV;
            end
         end
         pta_pkg::F_DIV: begin
            if (cnt_ff == 4'd0) begin
               state_in = pta_pkg::F_PUSH;
            end
         end
         pta_pkg::F_PUSH: begin
            if (push_ready) begin
               state_in = pta_pkg::F_IDLE;
            end
         end
         default: state_in = pta_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req.ready   = (state_ff == pta_pkg::F_IDLE);
      csr.ready   = 1'b1;
      push.valid  = (state_ff == pta_pkg::F_PUSH);
      push.target = nopot_ff ? 7'd0 : pta_pkg::target_of(dvd_ff, reverse_ff);
   end

   always_comb begin
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      cnt_in     = cnt_ff;
      nopot_in   = nopot_ff;
      reverse_in = reverse_ff;
      if (csr.valid && csr.ready) begin
         reverse_in = csr.reverse_direction;
      end
      if (accept) begin
         dvd_in   = {req.pot_sample, 8'h00} - {8'h00, req.pot_sample};
         den_in   = pta_pkg::FULL_SCALE - req.pot_sample;
         rem_in   = 8'd0;
         cnt_in   = pta_pkg::DIV_LAST_STEP;
         nopot_in = (req.pot_sample > pta_pkg::NO_POT_THRESHOLD);
      end else if (state_ff == pta_pkg::F_DIV) begin
         dvd_in = {dvd_ff[14:0], fits};
         rem_in = fits ? diff[7:0] : rem_sh[7:0];
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pta_pkg::F_IDLE;
         reverse_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         reverse_ff <= reverse_in;
      end
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      cnt_ff   <= cnt_in;
      nopot_ff <= nopot_in;
   end

endmodule

// ===== rtl/pta_queue.sv =====
// Short target queue between the front end and the ramp stepper.
module pta_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pta_pkg::tgt_beat_type push,
   output logic                  push_ready,
   output pta_pkg::tgt_beat_type pop,
   input  logic                  pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [6:0]       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop.valid  = (count_ff != '0);
   assign pop.target = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.target;
      end
   end

endmodule

// ===== rtl/pta_back.sv =====
// Back end: ramps the stored attenuation to each target one dB per beat.
`include "pot_to_attenuation_ramp_top_macros.svh"

module pta_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pta_pkg::tgt_beat_type pop,
   output logic                  pop_ready,
   pta_rsp_if.source             rsp
);

   pta_pkg::back_state_type state_ff, state_in;
   logic [6:0] current_ff, current_in;
   logic [6:0] target_ff, target_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] atten_ff, atten_in;
   logic       last_ff, last_in;
   logic       out_free;
   logic       step_fire;
   logic       do_pop;
   logic [6:0] step;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign do_pop   = pop.valid && pop_ready;
   assign step     = (current_ff < target_ff) ? current_ff + 7'd1 : current_ff - 7'd1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pta_pkg::B_IDLE: begin
            if (do_pop && (pop.target != current_ff)) begin
               state_in = pta_pkg::B_RAMP;
            end
         end
         pta_pkg::B_RAMP: begin
            if (step_fire && (step == target_ff)) begin
               state_in = pta_pkg::B_IDLE;
            end
         end
         default: state_in = pta_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop_ready          = (state_ff == pta_pkg::B_IDLE);
      step_fire          = (state_ff == pta_pkg::B_RAMP) && out_free;
      rsp.valid          = rsp_valid_ff;
      rsp.attenuation_db = atten_ff;
      rsp.last_step      = last_ff;
   end

   always_comb begin
      current_in   = current_ff;
      target_in    = target_ff;
      atten_in     = atten_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (do_pop) begin
         target_in = pop.target;
      end
      if (step_fire) begin
         current_in   = step;
         atten_in     = step;
         last_in      = (step == target_ff);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pta_pkg::B_IDLE;
         current_ff   <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         current_ff   <= current_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff <= target_in;
      atten_ff  <= atten_in;
      last_ff   <= last_in;
   end

   `PTA_ASSERT_NOW(a_ramp_not_done, clock, reset, state_ff == pta_pkg::B_RAMP, current_ff != target_ff, "ramp state with attenuation already at target")
   `PTA_ASSERT_NOW(a_beat_in_range, clock, reset, rsp_valid_ff, atten_ff <= pta_pkg::MAX_ATTEN, "step beyond the attenuation range")
   `PTA_ASSERT_NEXT(a_unit_step, clock, reset, step_fire, (current_ff == $past(current_ff) + 7'd1) || (current_ff == $past(current_ff) - 7'd1), "ramp moved by other than one dB")

endmodule

// ===== rtl/pot_to_attenuation_ramp_top.sv =====
// Top level of the pot-to-attenuation ramp block.
//
// req_chan carries one pot_sample per beat; rsp_chan returns the ramp of
// attenuation_db beats, one dB apart, with last_step set on the beat that
// reaches the new target; csr_chan writes reverse_direction and is always ready.
// A sample above 0xE0 targets 0 dB. A target equal to the stored attenuation
// gives no beats.
// The front end takes a sample when idle and runs a bit-serial division, then
// holds the target until a queue of QUEUE_DEPTH entries takes it.
// A sample above 0xE0 skips the division and goes straight to the queue.
// The back end pops a target when idle and emits one step per cycle while the
// output register is free, and pops the next target only after the ramp ends.
// The front end works on the next sample while the back end ramps.
// Reset sets the stored attenuation to 0 dB, clears reverse_direction and
// empties the queue. When the receiver stalls, the current step holds in the
// output register, the ramp pauses, and the queue and then req_chan back up.
module pot_to_attenuation_ramp_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic        clock,
   input logic        reset,
   pta_req_if.sink    req_chan,
   pta_rsp_if.source  rsp_chan,
   pta_csr_if.sink    csr_chan
);

   pta_pkg::tgt_beat_type push;
   pta_pkg::tgt_beat_type pop;
   logic                  push_ready;
   logic                  pop_ready;

   pta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr        (csr_chan),
      .push       (push),
      .push_ready (push_ready)
   );

   pta_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   pta_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );

endmodule
